[hw/rtl/barcode_quality_classifier_unit_defines.svh]
// assertion macros for the barcode quality classifier
`ifndef BARCODE_QUALITY_CLASSIFIER_UNIT_DEFINES_SVH
`define BARCODE_QUALITY_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define BQC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bqc check failed");

// next-cycle implication, sampled on aclk, off during reset
`define BQC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bqc check failed");

`endif

[hw/rtl/bqc_pkg.sv]
package bqc_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MAX_BASES_DEF   = 16;

    localparam int SEQ_W      = 48;
    localparam int LEN_W      = 8;
    localparam int QCHAR_W    = 7;
    localparam int INDEX_W    = 12;
    localparam int SUM_W      = 23;
    localparam int COUNT_W    = 16;
    localparam int BLEN_W     = 5;
    localparam int CUTOFF_W   = 7;
    localparam int TSIZE_W    = 13;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 64;

    localparam logic [QCHAR_W-1:0]  PHRED_OFFSET     = 7'd33;
    localparam logic [COUNT_W-1:0]  COUNT_MAX        = 16'hFFFF;
    localparam logic [BLEN_W-1:0]   RESET_BLEN       = 5'd15;
    localparam logic [CUTOFF_W-1:0] RESET_CUTOFF     = 7'd20;
    localparam logic [TSIZE_W-1:0]  RESET_TABLE_SIZE = 13'd0;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BARCODE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUAL    = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND       = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_LOW_QUALITY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_WRONG_SIZE  = 2'd3;

    localparam logic [1:0] REG_BARCODE_LENGTH = 2'd0;
    localparam logic [1:0] REG_QUALITY_CUTOFF = 2'd1;
    localparam logic [1:0] REG_TABLE_SIZE     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_READ,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [BLEN_W-1:0]   barcode_length;
        logic [CUTOFF_W-1:0] quality_cutoff;
        logic [TSIZE_W-1:0]  table_size;
    } cfg_t;

    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } read_info_t;

endpackage

[hw/rtl/bqc_table_ram.sv]
module bqc_table_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/bqc_accum.sv]
module bqc_accum import bqc_pkg::*; #(
    parameter int MAX_BASES = MAX_BASES_DEF,
    localparam int FULL_W = 3 * MAX_BASES,
    localparam int KW = (FULL_W < SEQ_W) ? FULL_W : SEQ_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [REQ_W-1:0]   in_req,
    input  logic [SEQ_W-1:0]   seq_code,
    input  logic [LEN_W-1:0]   seq_len,
    input  logic [QCHAR_W-1:0] quality_char,
    input  logic               clear,
    output read_info_t         info,
    output logic [KW-1:0]      code
);

    logic [KW-1:0]      code_reg,  code_next;
    logic [LEN_W-1:0]   len_reg,   len_next;
    logic [SUM_W-1:0]   sum_reg,   sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [QCHAR_W-1:0] score;

    // characters below the offset score zero
    assign score = (quality_char >= PHRED_OFFSET) ? quality_char - PHRED_OFFSET : '0;

    always_comb begin
        code_next  = code_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (clear) begin
            sum_next   = '0;
            count_next = '0;
        end else if (in_accept && in_req == REQ_BARCODE) begin
            code_next  = seq_code[KW-1:0];
            len_next   = seq_len;
            sum_next   = '0;
            count_next = '0;
        end else if (in_accept && in_req == REQ_QUAL && count_reg != COUNT_MAX) begin
            sum_next   = sum_reg + SUM_W'(score);
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg  <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            code_reg  <= code_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign info.length = len_reg;
    assign info.sum    = sum_reg;
    assign info.count  = count_reg;
    assign code        = code_reg;

endmodule

[hw/rtl/bqc_ctrl.sv]
module bqc_ctrl import bqc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_BASES = MAX_BASES_DEF,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int SW = $clog2(TABLE_DEPTH + 1),
    localparam int FULL_W = 3 * MAX_BASES,
    localparam int KW = (FULL_W < SEQ_W) ? FULL_W : SEQ_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                in_accept,
    input  logic [REQ_W-1:0]    in_req,
    input  logic                in_last,
    output logic                in_ready,
    input  read_info_t          info,
    input  logic [KW-1:0]       code,
    output logic                acc_clear,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic [KW-1:0]       rd_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [INDEX_W-1:0]  m_index,
    output logic [SEQ_W-1:0]    m_code
);

    state_t state_reg, state_next;

    logic [SW-1:0]       lo_reg;
    logic [SW-1:0]       hip1_reg;
    logic [AW-1:0]       mid_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [INDEX_W-1:0]  res_pos_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [SEQ_W-1:0]    m_code_reg;

    logic [SW-1:0]       n_entries;
    logic [BLEN_W-1:0]   n_bases;
    logic [6:0]          mask_shift;
    logic [FULL_W-1:0]   full_mask;
    logic [KW-1:0]       key_mask;
    logic [KW-1:0]       key;
    logic [KW-1:0]       entry_key;
    logic                key_eq;
    logic                key_lt;
    logic [SW-1:0]       span;
    logic [SW-1:0]       mid_calc;
    logic [SW-1:0]       mid_ext;
    logic [SW-1:0]       mid_inc;
    logic                more;
    logic                len_over;
    logic [SUM_W-1:0]    cutoff_total;
    logic                qual_short;
    logic [STATUS_W-1:0] eval_status;
    logic                out_free;
    logic                out_load;
    logic                final_qual;

    assign final_qual = in_accept && in_req == REQ_QUAL && in_last;

    assign n_entries = (int'(cfg.table_size) > TABLE_DEPTH) ? SW'(TABLE_DEPTH)
                                                          : SW'(cfg.table_size);

    // compare over the leading bases only
    assign n_bases    = (int'(cfg.barcode_length) > MAX_BASES) ? BLEN_W'(MAX_BASES)
                                                             : cfg.barcode_length;
    assign mask_shift = 7'(n_bases) * 7'd3;
    assign full_mask  = ~({FULL_W{1'b1}} >> mask_shift);
    assign key_mask   = KW'(full_mask);
    assign key        = code & key_mask;
    assign entry_key  = rd_data & key_mask;
    assign key_eq     = key == entry_key;
    assign key_lt     = key < entry_key;

    // hip1 is one past the upper bound
    assign span     = hip1_reg - lo_reg - SW'(1);
    assign mid_calc = lo_reg + (span >> 1);
    assign mid_ext  = SW'(mid_reg);
    assign mid_inc  = mid_ext + SW'(1);
    assign more     = key_lt ? (lo_reg < mid_ext) : (mid_inc < hip1_reg);

    assign len_over     = info.length > LEN_W'(cfg.barcode_length);
    assign cutoff_total = SUM_W'(cfg.quality_cutoff) * SUM_W'(info.count);
    assign qual_short   = info.sum < cutoff_total;
    assign eval_status  = len_over   ? STAT_WRONG_SIZE :
                          qual_short ? STAT_LOW_QUALITY : STAT_NOT_FOUND;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (final_qual) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (len_over || qual_short || n_entries == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (!key_eq && more) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_READ: rd_en    = 1'b1;
            ST_OUT:  out_load = out_free;
            default: ;
        endcase
    end

    assign acc_clear = out_load;
    assign rd_addr   = AW'(mid_calc);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_EVAL: begin
                lo_reg         <= '0;
                hip1_reg       <= n_entries;
                res_status_reg <= eval_status;
                res_pos_reg    <= '0;
            end
            ST_READ: begin
                mid_reg <= AW'(mid_calc);
            end
            ST_CMP: begin
                if (key_eq) begin
                    res_status_reg <= STAT_FOUND;
                    res_pos_reg    <= INDEX_W'(mid_reg);
                end else if (key_lt) begin
                    hip1_reg <= mid_ext;
                end else begin
                    lo_reg <= mid_inc;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_pos_reg;
            m_code_reg   <= SEQ_W'(code);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_index  = m_index_reg;
    assign m_code   = m_code_reg;

endmodule

[hw/rtl/barcode_quality_classifier_unit.sv]
// Classifies sequencing reads against a sorted barcode table. Load, barcode
// and non-final quality words are taken one per cycle. After the final
// quality word of a read the input stalls while the read is judged: first
// the size and quality tests; then, unless a test fails or the table is
// empty, binary-search probes, each a table memory read and then the
// compare, until a match or an empty range; last the move of the result
// into the output register, which waits while that register is still held
// by the downstream side. The table memory has no reset; only loaded
// entries may be searched.
module barcode_quality_classifier_unit import bqc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_BASES = MAX_BASES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index, seq_code, seq_len, quality_char
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [REQ_W-1:0]     s_tuser,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // match_index, read_code
    output logic [M_TDATA_W-1:0] m_tdata,
    // status
    output logic [STATUS_W-1:0]  m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FULL_W = 3 * MAX_BASES;
    localparam int KW = (FULL_W < SEQ_W) ? FULL_W : SEQ_W;

    logic [BLEN_W-1:0]   blen_reg;
    logic [CUTOFF_W-1:0] cutoff_reg;
    logic [TSIZE_W-1:0]  tsize_reg;
    cfg_t                cfg;
    logic                cfg_write;

    logic [INDEX_W-1:0]  entry_index;
    logic [SEQ_W-1:0]    seq_code;
    logic [LEN_W-1:0]    seq_len;
    logic [QCHAR_W-1:0]  quality_char;
    logic                s_accept;

    read_info_t          info;
    logic [KW-1:0]       code;
    logic                acc_clear;
    logic                wr_en;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [KW-1:0]       rd_data;
    logic [INDEX_W-1:0]  m_index;
    logic [SEQ_W-1:0]    m_code;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blen_reg   <= RESET_BLEN;
            cutoff_reg <= RESET_CUTOFF;
            tsize_reg  <= RESET_TABLE_SIZE;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_BARCODE_LENGTH: blen_reg   <= pwdata[BLEN_W-1:0];
                REG_QUALITY_CUTOFF: cutoff_reg <= pwdata[CUTOFF_W-1:0];
                REG_TABLE_SIZE:     tsize_reg  <= pwdata[TSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BARCODE_LENGTH: prdata = PDATA_W'(blen_reg);
            REG_QUALITY_CUTOFF: prdata = PDATA_W'(cutoff_reg);
            REG_TABLE_SIZE:     prdata = PDATA_W'(tsize_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.barcode_length = blen_reg;
    assign cfg.quality_cutoff = cutoff_reg;
    assign cfg.table_size     = tsize_reg;

    assign entry_index  = s_tdata[11:0];
    assign seq_code     = s_tdata[59:12];
    assign seq_len      = s_tdata[67:60];
    assign quality_char = s_tdata[74:68];
    assign s_accept     = s_tvalid && s_tready;

    // loads beyond the table depth are dropped
    assign wr_en = s_accept && s_tuser == REQ_LOAD && int'(entry_index) < TABLE_DEPTH;

    bqc_accum #(
        .MAX_BASES(MAX_BASES)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (s_accept),
        .in_req      (s_tuser),
        .seq_code    (seq_code),
        .seq_len     (seq_len),
        .quality_char(quality_char),
        .clear       (acc_clear),
        .info        (info),
        .code        (code)
    );

    bqc_table_ram #(
        .DEPTH(TABLE_DEPTH),
        .WIDTH(KW)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(AW'(entry_index)),
        .wr_data(seq_code[KW-1:0]),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    bqc_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_BASES  (MAX_BASES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_accept(s_accept),
        .in_req   (s_tuser),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .info     (info),
        .code     (code),
        .acc_clear(acc_clear),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_status (m_tuser),
        .m_index  (m_index),
        .m_code   (m_code)
    );

    assign m_tdata = {4'b0000, m_code, m_index};

endmodule

[hw/rtl/bqc_checker.sv]
`include "barcode_quality_classifier_unit_defines.svh"

module bqc_checker import bqc_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [REQ_W-1:0]     s_tuser,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // a held result word does not change
    `BQC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // the final quality word of a read stops the input for the search
    `BQC_ASSERT_NEXT(a_last_stalls, s_tvalid && s_tready && s_tuser == REQ_QUAL && s_tlast, !s_tready)

    // the input only stops after a final quality word
    `BQC_ASSERT_IMPLY(a_stall_cause, $fell(s_tready), $past(s_tvalid && s_tuser == REQ_QUAL && s_tlast))

    // the index field is zero unless the read was found
    `BQC_ASSERT_IMPLY(a_index_zero, m_tvalid && m_tuser != STAT_FOUND, m_tdata[11:0] == '0)

endmodule

bind barcode_quality_classifier_unit bqc_checker u_bqc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
